### src/nnr_pkg.sv
package nnr_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int CFG_W   = 7;
    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam int COORD_W = 6;
    localparam int PIX_W   = 8;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // Divider widths: numerator 2*d*s + dsz, denominator 2*dsz, quotient below 128.
    localparam int NUM_W = 2 * CFG_W + 1;
    localparam int DEN_W = CFG_W + 1;
    localparam int QUO_W = CFG_W;
    localparam int CNT_W = $clog2(QUO_W);

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

    localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 7'd28;
    localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 7'd28;
    localparam logic [CFG_W-1:0] RST_DST_WIDTH  = 7'd32;
    localparam logic [CFG_W-1:0] RST_DST_HEIGHT = 7'd32;

    typedef struct packed {
        logic               func;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             range_error;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // A size register of zero acts as one, and a size above the limit acts as the limit.
    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v, input int limit);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (int'(v) > limit) begin
            r = CFG_W'(limit);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### src/nnr_div.sv
module nnr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [nnr_pkg::COORD_W-1:0]   i_coord,
    input  logic [nnr_pkg::CFG_W-1:0]     i_src_size,
    input  logic [nnr_pkg::CFG_W-1:0]     i_dst_size,
    output nnr_pkg::t_div_stat            o_stat,
    output logic [nnr_pkg::QUO_W-1:0]     o_quo
);
    import nnr_pkg::*;

    logic [NUM_W-1:0] w_d2;
    logic [NUM_W-1:0] w_s;
    logic [NUM_W-1:0] w_num;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [QUO_W-1:0] r_low;
    logic [DEN_W-1:0] r_den;
    logic [QUO_W-1:0] r_quo;

    assign w_d2  = NUM_W'({i_coord, 1'b0});
    assign w_s   = NUM_W'(i_src_size);
    assign w_num = w_d2 * w_s + NUM_W'(i_dst_size);

    // One restoring step per cycle. The upper numerator bits are already below the
    // denominator because the quotient fits in QUO_W bits.
    assign w_trial = {r_rem, r_low[QUO_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_low <= {r_low[QUO_W-2:0], 1'b0};
                r_quo <= {r_quo[QUO_W-2:0], w_ge};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_rem  <= w_num[NUM_W-1:QUO_W];
                r_low  <= w_num[QUO_W-1:0];
                r_den  <= {i_dst_size, 1'b0};
                r_cnt  <= CNT_W'(QUO_W - 1);
                r_busy <= 1'b1;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule

### src/nnr_store.sv
module nnr_store #(
    parameter int MAX_WIDTH  = nnr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = nnr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] i_waddr,
    input  logic [nnr_pkg::PIX_W-1:0]              i_wdata,
    input  logic                                   i_re,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] i_raddr,
    output logic [nnr_pkg::PIX_W-1:0]              o_rdata
);
    import nnr_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/nearest_neighbor_image_rescale.sv
// Nearest-neighbor grey image rescaler with a frame store.
// Input channel (i_in_valid / o_in_ready / i_in_data): a load request (func 0)
// writes pixel_in at source (col, row); loads outside the source size are dropped.
// A fetch request (func 1) names a destination (col, row) and returns one result on
// the output channel (o_out_valid / i_out_ready / o_out_data) holding the nearest
// source pixel, or pixel 0 with range_error set when the position lies outside the
// destination size.
// Loads can be accepted back to back. An in-range fetch runs from acceptance to
// o_out_valid through a shared restoring divider for each coordinate (a load step
// plus seven quotient bits), followed by one frame store read and the output register.
// An out-of-range fetch skips the divider and goes from acceptance straight to
// S_DONE, and from there into the output register.
// o_in_ready is low while a fetch is in flight; the result sits in an output register,
// so a new request is taken while a result waits, and a finished fetch holds there
// until the output register is free.
// Size registers sit on the APB port at byte addresses 0, 4, 8 and 12.
// Reset restores the size registers to 28, 28, 32, 32 and empties the output register;
// the frame store is not cleared and must be loaded before it is fetched from.
module nearest_neighbor_image_rescale #(
    parameter int MAX_WIDTH  = nnr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = nnr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  nnr_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output nnr_pkg::t_out_item            o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nnr_pkg::APB_AW-1:0]    paddr,
    input  logic [nnr_pkg::APB_DW-1:0]    pwdata,
    output logic [nnr_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import nnr_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVX,
        S_DIVY,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [CFG_W-1:0] r_src_w;
    logic [CFG_W-1:0] r_src_h;
    logic [CFG_W-1:0] r_dst_w;
    logic [CFG_W-1:0] r_dst_h;
    logic [COORD_W-1:0] r_row;
    logic [CFG_W-1:0] r_sx;
    logic             r_err;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [CFG_W-1:0] w_sw;
    logic [CFG_W-1:0] w_sh;
    logic [CFG_W-1:0] w_dw;
    logic [CFG_W-1:0] w_dh;
    logic             w_in_acc;
    logic             w_cfg_wr;
    logic             w_load_ok;
    logic             w_fetch_ok;
    logic             w_mem_we;
    logic             w_mem_re;
    logic [AW-1:0]    w_waddr;
    logic [AW-1:0]    w_raddr;
    logic [PIX_W-1:0] w_rdata;
    logic             w_div_start;
    logic [COORD_W-1:0] w_div_coord;
    logic [CFG_W-1:0] w_div_src;
    logic [CFG_W-1:0] w_div_dst;
    logic [QUO_W-1:0] w_quo;
    logic [CFG_W-1:0] w_lim;
    logic [CFG_W-1:0] w_coord;
    logic             w_out_free;
    t_div_stat        w_div_stat;

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= RST_SRC_WIDTH;
            r_src_h <= RST_SRC_HEIGHT;
            r_dst_w <= RST_DST_WIDTH;
            r_dst_h <= RST_DST_HEIGHT;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_SRC_WIDTH:  r_src_w <= pwdata[CFG_W-1:0];
                REG_SRC_HEIGHT: r_src_h <= pwdata[CFG_W-1:0];
                REG_DST_WIDTH:  r_dst_w <= pwdata[CFG_W-1:0];
                REG_DST_HEIGHT: r_dst_h <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SRC_WIDTH:  prdata = APB_DW'(r_src_w);
            REG_SRC_HEIGHT: prdata = APB_DW'(r_src_h);
            REG_DST_WIDTH:  prdata = APB_DW'(r_dst_w);
            REG_DST_HEIGHT: prdata = APB_DW'(r_dst_h);
            default:        prdata = '0;
        endcase
    end

    assign w_sw = eff_size(r_src_w, MAX_WIDTH);
    assign w_sh = eff_size(r_src_h, MAX_HEIGHT);
    assign w_dw = eff_size(r_dst_w, CFG_MAX);
    assign w_dh = eff_size(r_dst_h, CFG_MAX);

    // Request decode.
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_load_ok  = ({1'b0, i_in_data.col} < w_sw) && ({1'b0, i_in_data.row} < w_sh);
    assign w_fetch_ok = ({1'b0, i_in_data.col} < w_dw) && ({1'b0, i_in_data.row} < w_dh);
    assign w_mem_we   = w_in_acc && (i_in_data.func == FUNC_LOAD) && w_load_ok;
    assign w_waddr    = AW'(int'(i_in_data.row) * MAX_WIDTH + int'(i_in_data.col));

    // The divider maps the column first, then the row.
    assign w_div_coord = (r_state == S_IDLE) ? i_in_data.col : r_row;
    assign w_div_src   = (r_state == S_IDLE) ? w_sw : w_sh;
    assign w_div_dst   = (r_state == S_IDLE) ? w_dw : w_dh;
    assign w_div_start = (w_in_acc && (i_in_data.func == FUNC_FETCH) && w_fetch_ok)
                       || ((r_state == S_DIVX) && w_div_stat.done);

    // Clamp the rounded coordinate to the last source column or row.
    assign w_lim   = ((r_state == S_DIVX) ? w_sw : w_sh) - CFG_W'(1);
    assign w_coord = (w_quo > w_lim) ? w_lim : w_quo;

    assign w_mem_re = (r_state == S_DIVY) && w_div_stat.done;
    assign w_raddr  = AW'(int'(w_coord) * MAX_WIDTH + int'(r_sx));

    assign w_out_free = !r_out_valid || i_out_ready;

    nnr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_coord    (w_div_coord),
        .i_src_size (w_div_src),
        .i_dst_size (w_div_dst),
        .o_stat     (w_div_stat),
        .o_quo      (w_quo)
    );

    nnr_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in_data.pixel_in),
        .i_re    (w_mem_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_in_data.func == FUNC_FETCH)) begin
                        r_row <= i_in_data.row;
                        if (w_fetch_ok) begin
                            r_err   <= 1'b0;
                            r_state <= S_DIVX;
                        end else begin
                            r_err   <= 1'b1;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIVX: begin
                    if (w_div_stat.done) begin
                        r_sx    <= w_coord;
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (w_div_stat.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.pixel_out       <= r_err ? '0 : w_rdata;
                        r_out.range_error     <= r_err;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider started while busy");

    a_err_zero_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.range_error) |-> (o_out_data.pixel_out == '0))
        else $error("range error result carries a nonzero pixel");

    a_sx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVY) |-> (r_sx < w_sw))
        else $error("mapped column beyond source width");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_we && w_mem_re))
        else $error("frame store written and read in the same cycle");

    a_done_leaves_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> ((r_state == S_DIVX) || (r_state == S_DIVY)))
        else $error("divider finished outside a mapping step");

endmodule

### verif/tb_nearest_neighbor_image_rescale.sv
module tb_nearest_neighbor_image_rescale;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_W        = nnr_pkg::DEF_MAX_WIDTH;
    localparam int STORE_H        = nnr_pkg::DEF_MAX_HEIGHT;
    localparam int FETCH_SETTLE   = 24;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_REQUESTS = 120;
    localparam int DIR_ROWS       = 29;

    typedef struct packed {
        logic                      is_size;
        logic [1:0]                size_idx;
        logic [nnr_pkg::CFG_W-1:0] size_val;
        nnr_pkg::t_in_item         req;
        logic                      known;
        nnr_pkg::t_out_item        known_out;
    } t_dir_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    nnr_pkg::t_in_item    i_in_data   = '0;
    logic                 i_out_ready = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [3:0]           paddr       = '0;
    logic [31:0]          pwdata      = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    nnr_pkg::t_out_item   o_out_data;
    logic [31:0]          prdata;
    logic                 pready;

    logic [nnr_pkg::CFG_W-1:0] size_copy [4];
    logic [7:0]                frame_copy [STORE_W*STORE_H];
    bit                        pixel_loaded [STORE_W*STORE_H];
    nnr_pkg::t_out_item        fetch_results_due [$];
    t_dir_row                  dir_rows [DIR_ROWS];
    int unsigned               effective_requests = 0;
    int                        fail_count = 0;
    int                        quiet_cycles = 0;
    bit                        no_idle = 1'b0;

    nearest_neighbor_image_rescale dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 i_clk = ~i_clk;

    // Size as the block uses it: zero acts as one, and the source is capped by the store.
    function automatic int unsigned dim(input logic [1:0] idx);
        int unsigned cap;
        int unsigned v;
        if (idx == nnr_pkg::REG_SRC_WIDTH) begin
            cap = STORE_W;
        end else if (idx == nnr_pkg::REG_SRC_HEIGHT) begin
            cap = STORE_H;
        end else begin
            cap = nnr_pkg::CFG_MAX;
        end
        v = size_copy[idx];
        if (v == 0) begin
            return 1;
        end
        return (v > cap) ? cap : v;
    endfunction

    // Rounds d*s/dsz half up, then clamps to the last source index.
    function automatic int unsigned nearest_src(input int unsigned d, input int unsigned s,
                                                input int unsigned dsz);
        int unsigned q;
        q = (2 * d * s + dsz) / (2 * dsz);
        return (q > s - 1) ? s - 1 : q;
    endfunction

    function automatic bit fetch_in_range(input logic [5:0] col, input logic [5:0] row);
        return col < dim(nnr_pkg::REG_DST_WIDTH) && row < dim(nnr_pkg::REG_DST_HEIGHT);
    endfunction

    function automatic int unsigned fetch_addr(input logic [5:0] col, input logic [5:0] row);
        int unsigned sx;
        int unsigned sy;
        sx = nearest_src(col, dim(nnr_pkg::REG_SRC_WIDTH), dim(nnr_pkg::REG_DST_WIDTH));
        sy = nearest_src(row, dim(nnr_pkg::REG_SRC_HEIGHT), dim(nnr_pkg::REG_DST_HEIGHT));
        return sy * STORE_W + sx;
    endfunction

    // Updates the frame store copy; returns 1 when the request produces a result.
    function automatic bit rescale_predict(input nnr_pkg::t_in_item it,
                                           output nnr_pkg::t_out_item res);
        int unsigned a;
        res = '0;
        if (it.func == nnr_pkg::FUNC_LOAD) begin
            if (it.col < dim(nnr_pkg::REG_SRC_WIDTH) && it.row < dim(nnr_pkg::REG_SRC_HEIGHT)) begin
                a = it.row * STORE_W + it.col;
                frame_copy[a] = it.pixel_in;
                pixel_loaded[a] = 1'b1;
            end
            return 1'b0;
        end
        if (!fetch_in_range(it.col, it.row)) begin
            res.range_error = 1'b1;
            return 1'b1;
        end
        res.pixel_out = frame_copy[fetch_addr(it.col, it.row)];
        return 1'b1;
    endfunction

    function automatic t_dir_row row_req(input logic func, input logic [5:0] col,
                                         input logic [5:0] row, input logic [7:0] pix);
        t_dir_row r;
        r = '0;
        r.req.func = func;
        r.req.col = col;
        r.req.row = row;
        r.req.pixel_in = pix;
        return r;
    endfunction

    function automatic t_dir_row row_known(input logic [5:0] col, input logic [5:0] row,
                                           input logic [7:0] pix, input logic err);
        t_dir_row r;
        r = row_req(nnr_pkg::FUNC_FETCH, col, row, 8'h00);
        r.known = 1'b1;
        r.known_out.pixel_out = pix;
        r.known_out.range_error = err;
        return r;
    endfunction

    function automatic t_dir_row row_size(input logic [1:0] idx,
                                          input logic [nnr_pkg::CFG_W-1:0] val);
        t_dir_row r;
        r = '0;
        r.is_size = 1'b1;
        r.size_idx = idx;
        r.size_val = val;
        return r;
    endfunction

    function automatic logic [nnr_pkg::CFG_W-1:0] pick_size(input bit is_src);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (is_src) begin
            if (r < 80) return 7'($urandom_range(1, 16));
            if (r < 90) return 7'd0;
            return 7'($urandom_range(64, 127));
        end
        if (r < 70) return 7'($urandom_range(1, 64));
        if (r < 85) return 7'd0;
        return 7'($urandom_range(65, 127));
    endfunction

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (fetch_results_due.size() != 0);
    endtask

    task automatic push_request(input nnr_pkg::t_in_item it, input bit known,
                                input nnr_pkg::t_out_item known_out);
        nnr_pkg::t_out_item predicted;
        int gap;
        gap = (!no_idle && $urandom_range(0, 99) < 35) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        effective_requests++;
        if (rescale_predict(it, predicted)) begin
            fetch_results_due.push_back(known ? known_out : predicted);
        end
    endtask

    // Sizes change only with the block idle; a load leaves no result to wait on,
    // so the FETCH_SETTLE wait covers one still in flight.
    task automatic write_size(input logic [1:0] idx, input logic [nnr_pkg::CFG_W-1:0] val);
        drain_results();
        repeat (FETCH_SETTLE) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        size_copy[idx] = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_request();
        nnr_pkg::t_in_item  it;
        nnr_pkg::t_in_item  fill;
        nnr_pkg::t_out_item none;
        int unsigned        pick;
        int unsigned        a;
        none = '0;
        it = '0;
        pick = $urandom_range(0, 99);
        it.pixel_in = 8'($urandom_range(0, 255));
        it.col = 6'($urandom_range(0, 63));
        it.row = 6'($urandom_range(0, 63));
        if (pick < 50) begin
            it.func = nnr_pkg::FUNC_LOAD;
            if (pick < 40) begin
                it.col = 6'($urandom_range(0, dim(nnr_pkg::REG_SRC_WIDTH) - 1));
                it.row = 6'($urandom_range(0, dim(nnr_pkg::REG_SRC_HEIGHT) - 1));
            end
        end else begin
            it.func = nnr_pkg::FUNC_FETCH;
            if (pick < 90) begin
                it.col = 6'($urandom_range(0, (dim(nnr_pkg::REG_DST_WIDTH) > 64) ? 63 :
                                             dim(nnr_pkg::REG_DST_WIDTH) - 1));
                it.row = 6'($urandom_range(0, (dim(nnr_pkg::REG_DST_HEIGHT) > 64) ? 63 :
                                             dim(nnr_pkg::REG_DST_HEIGHT) - 1));
            end
            // A fetch must never land on a pixel that was never loaded, so load it first.
            if (fetch_in_range(it.col, it.row)) begin
                a = fetch_addr(it.col, it.row);
                if (!pixel_loaded[a]) begin
                    fill = '0;
                    fill.func = nnr_pkg::FUNC_LOAD;
                    fill.col = 6'(a % STORE_W);
                    fill.row = 6'(a / STORE_W);
                    fill.pixel_in = 8'($urandom_range(0, 255));
                    push_request(fill, 1'b0, none);
                end
            end
        end
        push_request(it, 1'b0, none);
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(0, 99) >= 35);
    end

    always @(posedge i_clk) begin
        nnr_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (fetch_results_due.size() == 0) begin
                $error("result with no fetch pending: pixel_out %0h range_error %0b",
                       o_out_data.pixel_out, o_out_data.range_error);
                fail_count++;
            end else begin
                want = fetch_results_due.pop_front();
                if (o_out_data.pixel_out !== want.pixel_out) begin
                    $error("pixel_out: expected %0h, got %0h",
                           want.pixel_out, o_out_data.pixel_out);
                    fail_count++;
                end
                if (o_out_data.range_error !== want.range_error) begin
                    $error("range_error: expected %0b, got %0b",
                           want.range_error, o_out_data.range_error);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned phase_start;
        size_copy[nnr_pkg::REG_SRC_WIDTH]  = nnr_pkg::RST_SRC_WIDTH;
        size_copy[nnr_pkg::REG_SRC_HEIGHT] = nnr_pkg::RST_SRC_HEIGHT;
        size_copy[nnr_pkg::REG_DST_WIDTH]  = nnr_pkg::RST_DST_WIDTH;
        size_copy[nnr_pkg::REG_DST_HEIGHT] = nnr_pkg::RST_DST_HEIGHT;
        dir_rows = '{
            row_req(nnr_pkg::FUNC_LOAD, 6'd0, 6'd0, 8'hFF),
            row_req(nnr_pkg::FUNC_LOAD, 6'd27, 6'd27, 8'h00),
            row_req(nnr_pkg::FUNC_LOAD, 6'd63, 6'd63, 8'hAA),
            row_req(nnr_pkg::FUNC_LOAD, 6'd28, 6'd0, 8'h11),
            row_known(6'd0, 6'd0, 8'hFF, 1'b0),
            row_known(6'd31, 6'd31, 8'h00, 1'b0),
            row_known(6'd32, 6'd5, 8'h00, 1'b1),
            row_known(6'd3, 6'd63, 8'h00, 1'b1),
            row_size(nnr_pkg::REG_SRC_WIDTH, 7'd0),
            row_size(nnr_pkg::REG_SRC_HEIGHT, 7'd0),
            row_size(nnr_pkg::REG_DST_WIDTH, 7'd127),
            row_size(nnr_pkg::REG_DST_HEIGHT, 7'd127),
            row_known(6'd63, 6'd63, 8'hFF, 1'b0),
            row_req(nnr_pkg::FUNC_LOAD, 6'd1, 6'd0, 8'h55),
            row_req(nnr_pkg::FUNC_LOAD, 6'd0, 6'd0, 8'h3C),
            row_req(nnr_pkg::FUNC_FETCH, 6'd40, 6'd20, 8'hFF),
            row_size(nnr_pkg::REG_SRC_WIDTH, 7'd127),
            row_size(nnr_pkg::REG_SRC_HEIGHT, 7'd100),
            row_size(nnr_pkg::REG_DST_WIDTH, 7'd0),
            row_size(nnr_pkg::REG_DST_HEIGHT, 7'd1),
            row_req(nnr_pkg::FUNC_LOAD, 6'd63, 6'd63, 8'h5A),
            row_req(nnr_pkg::FUNC_FETCH, 6'd0, 6'd0, 8'h00),
            row_known(6'd1, 6'd0, 8'h00, 1'b1),
            row_size(nnr_pkg::REG_DST_WIDTH, 7'd64),
            row_size(nnr_pkg::REG_DST_HEIGHT, 7'd64),
            row_known(6'd63, 6'd63, 8'h5A, 1'b0),
            row_req(nnr_pkg::FUNC_FETCH, 6'd27, 6'd27, 8'h00),
            row_req(nnr_pkg::FUNC_LOAD, 6'd31, 6'd40, 8'hC3),
            row_req(nnr_pkg::FUNC_FETCH, 6'd31, 6'd40, 8'h00)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            if (dir_rows[k].is_size) begin
                write_size(dir_rows[k].size_idx, dir_rows[k].size_val);
            end else begin
                push_request(dir_rows[k].req, dir_rows[k].known, dir_rows[k].known_out);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_size(nnr_pkg::REG_SRC_WIDTH, pick_size(1'b1));
            write_size(nnr_pkg::REG_SRC_HEIGHT, pick_size(1'b1));
            write_size(nnr_pkg::REG_DST_WIDTH, pick_size(1'b0));
            write_size(nnr_pkg::REG_DST_HEIGHT, pick_size(1'b0));
            // One whole phase runs with neither side ever idling.
            no_idle = (p == 3);
            phase_start = effective_requests;
            while (effective_requests < phase_start + PHASE_REQUESTS) begin
                if (p == 5 && effective_requests == phase_start + PHASE_REQUESTS / 2) begin
                    drain_results();
                end
                random_request();
            end
        end

        drain_results();
        repeat (FETCH_SETTLE) @(posedge i_clk);
        if (fail_count == 0 && fetch_results_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
src/nnr_pkg.sv
src/nnr_div.sv
src/nnr_store.sv
src/nearest_neighbor_image_rescale.sv
verif/tb_nearest_neighbor_image_rescale.sv
